@@ hw/rtl/scba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants of the size-class bitmap allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int HEAP_NUM_W = 4;
    localparam int ORD_W      = 3;
    localparam int ROW_W      = 64;
    localparam int SLOT_W     = 6;
    localparam int LIM_W      = SLOT_W + 1;
    localparam int TOP_W      = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_TOP_ORDER = 1'b0;
    localparam logic [TOP_W-1:0]     TOP_RESET     = 3'd6;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_HEAP   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OPEN,
        S_FREE_RD,
        S_FREE_WR,
        S_RESULT
    } t_state;

endpackage

@@ hw/rtl/scba_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_req_if
// Request channel: allocate or free transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [scba_pkg::DATA_W-1:0]  request_bytes;
    logic [scba_pkg::DATA_W-1:0]  free_address;
    logic [scba_pkg::DATA_W-1:0]  free_size;

    modport source (
        output valid, action, request_bytes, free_address, free_size,
        input  ready
    );
    modport sink (
        input  valid, action, request_bytes, free_address, free_size,
        output ready
    );
endinterface

@@ hw/rtl/scba_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface scba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [scba_pkg::STATUS_W-1:0]  status;
    logic [scba_pkg::DATA_W-1:0]    block_address;
    logic [scba_pkg::DATA_W-1:0]    block_bytes;
    logic [scba_pkg::HEAP_NUM_W-1:0] heap_number;
    logic [scba_pkg::DATA_W-1:0]    heap_offset;

    modport source (
        output valid, status, block_address, block_bytes, heap_number, heap_offset,
        input  ready
    );
    modport sink (
        input  valid, status, block_address, block_bytes, heap_number, heap_offset,
        output ready
    );
endinterface

@@ hw/rtl/size_class_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator
// Segregated size-class allocator over per-heap occupancy bitmaps.
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// i_req     in   valid/ready      action, request_bytes, free_address, free_size
// o_rsp     out  valid/ready      status, block_address, block_bytes,
//                                 heap_number, heap_offset
// apb       in   psel/penable     top_order at byte address 0
//
// Allocate: decode, then per heap scanned one row read and one
// find-first-zero check, then opening a new heap if all are full, then result.
// Free: decode, row read, row write, result. Too-large requests
// and ignored frees: decode, result.
// One transaction at a time; the next is taken once the result is loaded.
// The result register holds while o_rsp.ready is low; a new request may
// be accepted meanwhile. Synchronous reset; occupancy rows read as zero
// through per-row valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator #(
    parameter int PAGE_SHIFT      = 16,
    parameter int MAX_ORDER       = 6,
    parameter int HEAPS_PER_CLASS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    scba_req_if.sink                       i_req,
    scba_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [scba_pkg::PADDR_W-1:0]   paddr,
    input  logic [scba_pkg::PDATA_W-1:0]   pwdata,
    output logic [scba_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int CLASS_COUNT = MAX_ORDER + 1;
    localparam int ROWS        = CLASS_COUNT * HEAPS_PER_CLASS;
    localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W       = $clog2(HEAPS_PER_CLASS + 1);

    localparam int DW = scba_pkg::DATA_W;
    localparam int OW = scba_pkg::ORD_W;
    localparam int RW = scba_pkg::ROW_W;
    localparam int SW = scba_pkg::SLOT_W;
    localparam int LW = scba_pkg::LIM_W;
    localparam int TW = scba_pkg::TOP_W;

    localparam logic [OW-1:0]    MAX_ORD  = OW'(MAX_ORDER);
    localparam logic [CNT_W-1:0] HEAPS_C  = CNT_W'(HEAPS_PER_CLASS);
    localparam logic [DW:0]      PAGE_M1  = (DW+1)'((64'd1 << PAGE_SHIFT) - 64'd1);

    scba_pkg::t_state r_state, n_state;

    logic [TW-1:0]                 r_top;
    logic                          r_action, n_action;
    logic [DW-1:0]                 r_req_bytes, n_req_bytes;
    logic [DW-1:0]                 r_free_addr, n_free_addr;
    logic [DW-1:0]                 r_free_size, n_free_size;
    logic [OW-1:0]                 r_ord, n_ord;
    logic [CNT_W-1:0]              r_h, n_h;
    logic [SW-1:0]                 r_slot, n_slot;
    logic [SW-1:0]                 r_j, n_j;
    logic                          r_hit, n_hit;
    logic [scba_pkg::STATUS_W-1:0] r_status, n_status;
    logic [CNT_W-1:0]              r_heaps_open [CLASS_COUNT];
    logic                          r_row_vld [ROWS];
    logic [RW-1:0]                 r_rows [ROWS];
    logic [RW-1:0]                 r_rd_data;
    logic                          r_rd_vld;

    logic                             r_out_valid;
    logic [scba_pkg::STATUS_W-1:0]    r_out_status;
    logic [DW-1:0]                    r_out_addr;
    logic [DW-1:0]                    r_out_bytes;
    logic [scba_pkg::HEAP_NUM_W-1:0]  r_out_heap;
    logic [DW-1:0]                    r_out_offset;

    logic              req_fire;
    logic              cfg_wr;
    logic              out_load;
    logic [TW-1:0]     eff_top;
    logic [DW-1:0]     heap_bytes;
    logic              too_large;
    logic [DW-1:0]     size_sel;
    logic [DW:0]       size_sum;
    logic [DW:0]       pages;
    logic [DW:0]       pages_m1;
    logic              ord_big;
    logic [OW-1:0]     ord_raw;
    logic [OW-1:0]     dec_ord;
    logic [LW-1:0]     dec_lim;
    logic [DW-1:0]     hidx;
    logic              free_ok;
    logic [ROW_AW-1:0] row_addr;
    logic [RW-1:0]     row_cur;
    logic [LW-1:0]     scan_lim;
    logic [RW-1:0]     scan_mask;
    logic [RW-1:0]     row_fill;
    logic              row_full;
    logic [SW-1:0]     ffz;
    logic [CNT_W-1:0]  h_inc;
    logic              open_ok;
    logic              mem_we;
    logic [RW-1:0]     mem_wdata;
    logic [DW-1:0]     res_addr;
    logic [DW-1:0]     res_bytes;
    logic [DW-1:0]     res_offset;

    // handshakes
    assign req_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == scba_pkg::S_IDLE);
    assign out_load = (r_state == scba_pkg::S_RESULT) && (!r_out_valid || o_rsp.ready);

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[scba_pkg::PADDR_W-1] == scba_pkg::REG_TOP_ORDER);
    assign pready = 1'b1;
    assign prdata = (paddr[scba_pkg::PADDR_W-1] == scba_pkg::REG_TOP_ORDER)
                    ? scba_pkg::PDATA_W'(r_top) : '0;

    // decode
    assign eff_top    = (r_top > TW'(MAX_ORDER)) ? TW'(MAX_ORDER) : r_top;
    assign heap_bytes = DW'(64'd1 << (PAGE_SHIFT + int'(eff_top)));
    assign too_large  = (r_req_bytes > heap_bytes);
    assign size_sel   = (r_action == scba_pkg::ACT_FREE) ? r_free_size : r_req_bytes;
    assign size_sum   = {1'b0, size_sel} + PAGE_M1;
    assign pages      = size_sum >> PAGE_SHIFT;
    assign pages_m1   = (pages == '0) ? '0 : (pages - (DW+1)'(1));
    assign ord_big    = ((pages_m1 >> eff_top) != '0);

    always_comb begin
        ord_raw = '0;
        for (int i = 0; i < SW; i++) begin
            if (pages_m1[i]) ord_raw = OW'(i + 1);
        end
    end

    assign dec_ord = (ord_raw > MAX_ORD) ? MAX_ORD : ord_raw;
    assign dec_lim = LW'(1) << (eff_top - dec_ord);
    assign hidx    = r_free_addr >> (PAGE_SHIFT + int'(eff_top));
    assign free_ok = !ord_big && (hidx < DW'(r_heaps_open[dec_ord]))
                     && (hidx < DW'(HEAPS_PER_CLASS));

    // row scan unit
    assign row_addr  = ROW_AW'(int'(r_ord) * HEAPS_PER_CLASS + int'(r_h));
    assign row_cur   = r_rd_vld ? r_rd_data : '0;
    assign scan_lim  = LW'(1) << (eff_top - r_ord);
    assign scan_mask = scan_lim[LW-1] ? '1 : ((RW'(1) << scan_lim) - RW'(1));
    assign row_fill  = row_cur | ~scan_mask;
    assign row_full  = (row_fill == '1);
    assign h_inc     = r_h + CNT_W'(1);
    assign open_ok   = (r_h < HEAPS_C);

    always_comb begin
        ffz = '0;
        for (int i = RW - 1; i >= 0; i--) begin
            if (!row_fill[i]) ffz = SW'(i);
        end
    end

    // result fields
    assign res_bytes  = DW'(64'd1 << (PAGE_SHIFT + int'(r_ord)));
    assign res_offset = DW'(r_j) << (PAGE_SHIFT + int'(r_ord));
    assign res_addr   = ((DW'(r_h) << (eff_top - r_ord)) | DW'(r_j))
                        << (PAGE_SHIFT + int'(r_ord));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scba_pkg::S_IDLE: begin
                if (req_fire) n_state = scba_pkg::S_DECODE;
            end
            scba_pkg::S_DECODE: begin
                if (r_action == scba_pkg::ACT_FREE) begin
                    n_state = free_ok ? scba_pkg::S_FREE_RD : scba_pkg::S_RESULT;
                end else begin
                    n_state = too_large ? scba_pkg::S_RESULT : scba_pkg::S_SCAN_RD;
                end
            end
            scba_pkg::S_SCAN_RD:  n_state = scba_pkg::S_SCAN_CHK;
            scba_pkg::S_SCAN_CHK: begin
                if (!row_full) begin
                    n_state = scba_pkg::S_RESULT;
                end else if (h_inc < r_heaps_open[r_ord]) begin
                    n_state = scba_pkg::S_SCAN_RD;
                end else begin
                    n_state = scba_pkg::S_OPEN;
                end
            end
            scba_pkg::S_OPEN:     n_state = scba_pkg::S_RESULT;
            scba_pkg::S_FREE_RD:  n_state = scba_pkg::S_FREE_WR;
            scba_pkg::S_FREE_WR:  n_state = scba_pkg::S_RESULT;
            scba_pkg::S_RESULT: begin
                if (out_load) n_state = scba_pkg::S_IDLE;
            end
            default: n_state = scba_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_action    = r_action;
        n_req_bytes = r_req_bytes;
        n_free_addr = r_free_addr;
        n_free_size = r_free_size;
        n_ord       = r_ord;
        n_h         = r_h;
        n_slot      = r_slot;
        n_j         = r_j;
        n_hit       = r_hit;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_wdata   = row_cur;
        case (r_state)
            scba_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_action    = i_req.action;
                    n_req_bytes = i_req.request_bytes;
                    n_free_addr = i_req.free_address;
                    n_free_size = i_req.free_size;
                end
            end
            scba_pkg::S_DECODE: begin
                n_hit    = 1'b0;
                n_status = scba_pkg::ST_DONE;
                n_ord    = dec_ord;
                if (r_action == scba_pkg::ACT_FREE) begin
                    n_h    = CNT_W'(hidx);
                    n_slot = SW'(r_free_addr >> (PAGE_SHIFT + int'(dec_ord)))
                             & SW'(dec_lim - LW'(1));
                end else begin
                    n_h = '0;
                    if (too_large) n_status = scba_pkg::ST_TOO_LARGE;
                end
            end
            scba_pkg::S_SCAN_CHK: begin
                if (!row_full) begin
                    n_j       = ffz;
                    n_hit     = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = row_cur | (RW'(1) << ffz);
                end else begin
                    n_h = h_inc;
                end
            end
            scba_pkg::S_OPEN: begin
                if (open_ok) begin
                    n_j       = '0;
                    n_hit     = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = RW'(1);
                end else begin
                    n_status = scba_pkg::ST_NO_HEAP;
                end
            end
            scba_pkg::S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = row_cur & ~(RW'(1) << r_slot);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scba_pkg::S_IDLE;
            r_top       <= scba_pkg::TOP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_top <= pwdata[TW-1:0];
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLASS_COUNT; k++) r_heaps_open[k] <= CNT_W'(1);
            for (int k = 0; k < ROWS; k++) r_row_vld[k] <= 1'b0;
        end else begin
            if (r_state == scba_pkg::S_OPEN && open_ok) begin
                r_heaps_open[r_ord] <= h_inc;
            end
            if (mem_we) r_row_vld[row_addr] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_req_bytes <= n_req_bytes;
        r_free_addr <= n_free_addr;
        r_free_size <= n_free_size;
        r_ord       <= n_ord;
        r_h         <= n_h;
        r_slot      <= n_slot;
        r_j         <= n_j;
        r_hit       <= n_hit;
        r_status    <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_hit ? res_addr : '0;
            r_out_bytes  <= r_hit ? res_bytes : '0;
            r_out_heap   <= r_hit ? scba_pkg::HEAP_NUM_W'(r_h) : '0;
            r_out_offset <= r_hit ? res_offset : '0;
        end
    end

    // occupancy memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_rows[row_addr] <= mem_wdata;
        r_rd_data <= r_rows[row_addr];
        r_rd_vld  <= r_row_vld[row_addr];
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.block_address = r_out_addr;
    assign o_rsp.block_bytes   = r_out_bytes;
    assign o_rsp.heap_number   = r_out_heap;
    assign o_rsp.heap_offset   = r_out_offset;

    // checks
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == scba_pkg::S_DECODE))
        else $error("accepted transaction did not enter decode");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scba_pkg::S_SCAN_CHK) |-> (r_h < r_heaps_open[r_ord]))
        else $error("scan past open heaps");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != scba_pkg::ST_DONE))
        |-> (o_rsp.block_address == '0 && o_rsp.block_bytes == '0))
        else $error("failed allocation carries nonzero fields");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_rsp.valid && r_state == scba_pkg::S_IDLE))
        else $error("result not presented");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the size-class bitmap allocator. A directed table
// (reset state, size extremes, bad and misaligned frees, top_order lowered
// over stale bits) is followed by random phases at several top_order
// settings. Every accepted request is run through a bench-side copy of the
// occupancy bitmaps and heap counts; each response is compared field by
// field with the oldest pending answer.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PAGE_SHIFT      = 16;
    localparam int MAX_ORDER       = 6;
    localparam int HEAPS_PER_CLASS = 16;
    localparam int CLASSES         = MAX_ORDER + 1;
    localparam int PHASE_ITEMS     = 200;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int DIR_COUNT       = 24;

    typedef struct packed {
        logic                          action;
        logic [scba_pkg::DATA_W-1:0]   request_bytes;
        logic [scba_pkg::DATA_W-1:0]   free_address;
        logic [scba_pkg::DATA_W-1:0]   free_size;
    } t_req;

    typedef struct packed {
        logic [scba_pkg::STATUS_W-1:0]   status;
        logic [scba_pkg::DATA_W-1:0]     block_address;
        logic [scba_pkg::DATA_W-1:0]     block_bytes;
        logic [scba_pkg::HEAP_NUM_W-1:0] heap_number;
        logic [scba_pkg::DATA_W-1:0]     heap_offset;
    } t_rsp;

    typedef struct packed {
        logic [scba_pkg::TOP_W-1:0] top;
        t_req                       req;
        logic                       typed;
        t_rsp                       rsp;
    } t_row;

    typedef struct {
        logic [scba_pkg::DATA_W-1:0] addr;
        logic [scba_pkg::DATA_W-1:0] bytes;
    } t_block;

    localparam t_rsp FREED   = '0;
    localparam t_rsp TOO_BIG = '{scba_pkg::ST_TOO_LARGE, 32'h0, 32'h0, 4'h0, 32'h0};

    localparam t_row DIR_ROWS [DIR_COUNT] = '{
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h0, 32'h0, 32'h0}, 1'b1,
            '{scba_pkg::ST_DONE, 32'h0, 32'h1_0000, 4'd0, 32'h0}},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h1, 32'h0, 32'h0}, 1'b1,
            '{scba_pkg::ST_DONE, 32'h1_0000, 32'h1_0000, 4'd0, 32'h1_0000}},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b1, TOO_BIG},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h40_0000, 32'h0, 32'h0}, 1'b1,
            '{scba_pkg::ST_DONE, 32'h0, 32'h40_0000, 4'd0, 32'h0}},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h40_0001, 32'h0, 32'h0}, 1'b1, TOO_BIG},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h40_0000, 32'h0, 32'h0}, 1'b1,
            '{scba_pkg::ST_DONE, 32'h40_0000, 32'h40_0000, 4'd1, 32'h0}},
        '{3'd6, '{scba_pkg::ACT_FREE, 32'h0, 32'h1_0000, 32'h1_0000}, 1'b1, FREED},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h1_0001, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd6, '{scba_pkg::ACT_FREE, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1, FREED},
        '{3'd6, '{scba_pkg::ACT_FREE, 32'h0, 32'hFFFF_FFFF, 32'h1_0000}, 1'b1, FREED},
        '{3'd6, '{scba_pkg::ACT_FREE, 32'h0, 32'h1, 32'h1}, 1'b1, FREED},
        '{3'd6, '{scba_pkg::ACT_FREE, 32'h0, 32'h0, 32'h0}, 1'b1, FREED},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h1_0000, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h1_0000, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd6, '{scba_pkg::ACT_ALLOC, 32'h1_0000, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd0, '{scba_pkg::ACT_ALLOC, 32'h1_0000, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd0, '{scba_pkg::ACT_ALLOC, 32'h1_0001, 32'h0, 32'h0}, 1'b1, TOO_BIG},
        '{3'd0, '{scba_pkg::ACT_FREE, 32'h0, 32'h0, 32'h2_0000}, 1'b1, FREED},
        '{3'd0, '{scba_pkg::ACT_FREE, 32'h0, 32'h0, 32'h1_0000}, 1'b1, FREED},
        '{3'd0, '{scba_pkg::ACT_ALLOC, 32'h0, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd0, '{scba_pkg::ACT_ALLOC, 32'h0, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd7, '{scba_pkg::ACT_ALLOC, 32'h40_0000, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd7, '{scba_pkg::ACT_ALLOC, 32'h0, 32'h0, 32'h0}, 1'b0, FREED},
        '{3'd7, '{scba_pkg::ACT_FREE, 32'h0, 32'h80_0000, 32'h40_0000}, 1'b1, FREED}
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [scba_pkg::PADDR_W-1:0] paddr;
    logic [scba_pkg::PDATA_W-1:0] pwdata;
    logic [scba_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    logic                         rsp_take = 1'b0;

    scba_req_if req_ch ();
    scba_rsp_if rsp_ch ();

    assign rsp_ch.ready = rsp_take;

    size_class_bitmap_allocator #(
        .PAGE_SHIFT      (PAGE_SHIFT),
        .MAX_ORDER       (MAX_ORDER),
        .HEAPS_PER_CLASS (HEAPS_PER_CLASS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // bench copy of allocator state
    logic [scba_pkg::ROW_W-1:0] occ_rows [CLASSES][HEAPS_PER_CLASS];
    int unsigned                heaps_used [CLASSES];
    logic [scba_pkg::TOP_W-1:0] top_reg;

    t_rsp        answer_q [$];
    t_block      live [$];
    bit          throttle = 1'b1;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_alloc = 0;
    int unsigned n_free = 0;
    int unsigned n_settings = 0;
    int unsigned status_seen [3] = '{0, 0, 0};

    function automatic int unsigned class_top();
        return (top_reg > MAX_ORDER) ? MAX_ORDER : int'(top_reg);
    endfunction

    // ceil(log2(pages)), zero and one page give order 0
    function automatic int unsigned size_order(input logic [scba_pkg::DATA_W-1:0] bytes);
        logic [63:0] pages;
        int unsigned ord;
        pages = ({32'd0, bytes} + ((64'd1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
        ord = 0;
        if (pages > 1) begin
            pages = pages - 1;
            while (pages != 0) begin
                ord++;
                pages = pages >> 1;
            end
        end
        return ord;
    endfunction

    function automatic t_rsp serve_request(input t_req r);
        t_rsp        res;
        int unsigned t, ord, slots, h, j;
        logic [63:0] hbytes, blk, mask, row, hidx, slot;
        res = '0;
        t = class_top();
        hbytes = 64'd1 << (PAGE_SHIFT + t);
        if (r.action == scba_pkg::ACT_FREE) begin
            ord = size_order(r.free_size);
            if (ord <= t) begin
                blk = 64'd1 << (PAGE_SHIFT + ord);
                hidx = {32'd0, r.free_address} / hbytes;
                if (hidx < heaps_used[ord]) begin
                    slot = ({32'd0, r.free_address} % hbytes) / blk;
                    occ_rows[ord][hidx][slot] = 1'b0;
                end
            end
            return res;
        end
        if ({32'd0, r.request_bytes} > hbytes) begin
            res.status = scba_pkg::ST_TOO_LARGE;
            return res;
        end
        ord = size_order(r.request_bytes);
        slots = 1 << (t - ord);
        mask = (slots >= 64) ? '1 : ((64'd1 << slots) - 1);
        blk = 64'd1 << (PAGE_SHIFT + ord);
        for (h = 0; h < heaps_used[ord]; h++) begin
            row = occ_rows[ord][h];
            if ((row & mask) != mask) begin
                j = 0;
                while (row[j]) j++;
                occ_rows[ord][h][j] = 1'b1;
                res.block_address = 32'((64'(h) * slots + j) * blk);
                res.block_bytes = 32'(blk);
                res.heap_number = 4'(h);
                res.heap_offset = 32'(64'(j) * blk);
                return res;
            end
        end
        if (heaps_used[ord] >= HEAPS_PER_CLASS) begin
            res.status = scba_pkg::ST_NO_HEAP;
            return res;
        end
        h = heaps_used[ord];
        heaps_used[ord] = h + 1;
        occ_rows[ord][h] = 64'd1;
        res.block_address = 32'(64'(h) * hbytes);
        res.block_bytes = 32'(blk);
        res.heap_number = 4'(h);
        return res;
    endfunction

    function automatic logic [scba_pkg::DATA_W-1:0] bytes_in_order(input int unsigned ord);
        if (ord == 0) return $urandom_range(32'h1_0000);
        return $urandom_range(32'd1 << (PAGE_SHIFT + ord),
                              (32'd1 << (PAGE_SHIFT + ord - 1)) + 1);
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned t, pick, idx;
        logic [63:0] hb;
        t = class_top();
        hb = 64'd1 << (PAGE_SHIFT + t);
        r.action = scba_pkg::ACT_ALLOC;
        r.request_bytes = $urandom;
        r.free_address = $urandom;
        r.free_size = $urandom;
        pick = $urandom_range(99);
        if (pick < 25 && live.size() != 0) begin
            idx = $urandom_range(live.size() - 1);
            r.action = scba_pkg::ACT_FREE;
            r.free_address = live[idx].addr;
            if ($urandom_range(3) == 0)
                r.free_address = r.free_address + $urandom_range(live[idx].bytes - 1);
            r.free_size = bytes_in_order(size_order(live[idx].bytes));
            live.delete(idx);
        end else if (pick < 35) begin
            r.action = scba_pkg::ACT_FREE;
            if ($urandom_range(1)) begin
                r.free_address = $urandom_range(32'(16 * hb - 1));
                r.free_size = bytes_in_order($urandom_range(t));
            end
        end else if (pick < 45) begin
            if ($urandom_range(1))
                r.request_bytes = 32'(hb) + $urandom_range(4096, 1);
        end else begin
            r.request_bytes = bytes_in_order($urandom_range(1) ? t : $urandom_range(t));
        end
        return r;
    endfunction

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // called and returns at a falling edge
    task automatic issue(input t_req r, input bit fixed, input t_rsp typed);
        t_rsp ans;
        while (throttle && $urandom_range(99) < 20) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= r.action;
        req_ch.request_bytes <= r.request_bytes;
        req_ch.free_address <= r.free_address;
        req_ch.free_size <= r.free_size;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        ans = serve_request(r);
        answer_q.push_back(fixed ? typed : ans);
        if (r.action == scba_pkg::ACT_FREE) begin
            n_free++;
        end else begin
            n_alloc++;
            if (ans.status == scba_pkg::ST_DONE)
                live.push_back('{ans.block_address, ans.block_bytes});
        end
        @(negedge i_clk);
    endtask

    task automatic write_top(input logic [scba_pkg::TOP_W-1:0] val);
        logic [scba_pkg::PDATA_W-1:0] got;
        req_ch.valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= scba_pkg::PADDR_W'(4 * int'(scba_pkg::REG_TOP_ORDER));
        pwdata <= scba_pkg::PDATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        top_reg = val;
        n_settings++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== scba_pkg::PDATA_W'(val))
            flag("top_order readback", scba_pkg::PDATA_W'(val), got);
    endtask

    always @(negedge i_clk) begin
        rsp_take <= throttle ? ($urandom_range(99) >= 20) : 1'b1;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (answer_q.size() == 0) begin
                flag("unrequested transaction: status", 32'h0, 32'(rsp_ch.status));
            end else begin
                want = answer_q.pop_front();
                if (rsp_ch.status < 3) status_seen[rsp_ch.status]++;
                if (rsp_ch.status !== want.status)
                    flag("status", 32'(want.status), 32'(rsp_ch.status));
                if (rsp_ch.block_address !== want.block_address)
                    flag("block_address", want.block_address, rsp_ch.block_address);
                if (rsp_ch.block_bytes !== want.block_bytes)
                    flag("block_bytes", want.block_bytes, rsp_ch.block_bytes);
                if (rsp_ch.heap_number !== want.heap_number)
                    flag("heap_number", 32'(want.heap_number), 32'(rsp_ch.heap_number));
                if (rsp_ch.heap_offset !== want.heap_offset)
                    flag("heap_offset", want.heap_offset, rsp_ch.heap_offset);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d answers pending", $time, answer_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned phase_tops [8];
        phase_tops = '{3, 0, 6, 1, 7, 4, 2, 5};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.action = scba_pkg::ACT_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.free_address = '0;
        req_ch.free_size = '0;
        foreach (occ_rows[k, h]) occ_rows[k][h] = '0;
        foreach (heaps_used[k]) heaps_used[k] = 1;
        top_reg = scba_pkg::TOP_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            if (DIR_ROWS[i].top != top_reg) write_top(DIR_ROWS[i].top);
            issue(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].rsp);
        end

        for (int p = 0; p < 8; p++) begin
            write_top(scba_pkg::TOP_W'(phase_tops[p]));
            throttle = (p != 2);
            live.delete();
            for (int n = 0; n < PHASE_ITEMS; n++) issue(random_request(), 1'b0, FREED);
            // release what is still held, in some phases only, so stale bits survive
            if ($urandom_range(1)) begin
                while (live.size() != 0) begin
                    t_req r;
                    r = '{scba_pkg::ACT_FREE, 32'h0, live[0].addr, live[0].bytes};
                    void'(live.pop_front());
                    issue(r, 1'b0, FREED);
                end
            end
        end
        throttle = 1'b1;

        req_ch.valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d allocations and %0d frees over %0d top_order writes",
                 n_alloc, n_free, n_settings);
        $display("Responses: %0d done, %0d too large, %0d class exhausted; %0d mismatches",
                 status_seen[0], status_seen[1], status_seen[2], fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
